// File: rtl/core/vle_pkg.sv
// ----------------------------------------------------------------------------
// vle_pkg: shared types and constants of the variable-length encoder
// Word layout, group geometry and the group selection function.
// ----------------------------------------------------------------------------
`default_nettype none

package vle_pkg;

	localparam int ValueW    = 64;
	localparam int GroupW    = 7;
	localparam int NumGroups = 10;
	localparam int IdxW      = 4;
	localparam int ExtW      = NumGroups * GroupW;

	localparam logic [7:0] ContBit  = 8'h80;
	localparam logic [7:0] MoreBit  = 8'h40;
	localparam logic [7:0] ZeroByte = 8'h00;
	localparam logic [GroupW-1:0] GroupMsk = 7'h7f;

	typedef logic [IdxW-1:0] grp_idx_t;

	typedef struct packed {
		logic [ValueW-1:0] mag;
		logic              neg;
		logic              smode;
	} vle_item_t;

	typedef struct packed {
		vle_item_t item;
		grp_idx_t  top;
		logic      hdr_empty;
	} vle_job_t;

	function automatic logic [GroupW-1:0] group_of(input logic [ValueW-1:0] mag,
		input grp_idx_t idx);
		logic [ExtW-1:0]   ext;
		logic [GroupW-1:0] grp;
		ext = {{(ExtW - ValueW){1'b0}}, mag};
		grp = '0;
		for (int i = 0; i < NumGroups; i++) begin
			if (idx == grp_idx_t'(i)) begin
				grp = ext[i*GroupW +: GroupW] & GroupMsk;
			end
		end
		return grp;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/vle_mag.sv
// ----------------------------------------------------------------------------
// vle_mag: first pipeline stage
// Registers the input word and forms the magnitude of a signed value.
// ----------------------------------------------------------------------------
`default_nettype none

module vle_mag
	import vle_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              take,
	input  wire logic [ValueW-1:0] value,
	input  wire logic              signed_mode,
	output logic                   v_s1,
	output vle_item_t              item_s1
);

	logic              neg;
	logic [ValueW-1:0] mag;

	assign neg = signed_mode & value[ValueW-1];
	assign mag = neg ? ({ValueW{1'b0}} - value) : value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (en && take) begin
			item_s1.mag   <= mag;
			item_s1.neg   <= neg;
			item_s1.smode <= signed_mode;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/vle_scan.sv
// ----------------------------------------------------------------------------
// vle_scan: second and third pipeline stages
// Finds the highest nonzero group, then checks whether a signed header
// byte must stand alone ahead of that group.
// ----------------------------------------------------------------------------
`default_nettype none

module vle_scan
	import vle_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      v_s1,
	input  wire vle_item_t item_s1,
	input  wire logic      ser_ready,
	output logic           s2_free,
	output logic           v_s3,
	output vle_job_t       job_s3
);

	logic           v_s2;
	vle_item_t      item_s2;
	grp_idx_t       top_s2;
	logic           en3;
	grp_idx_t       top_c;
	logic [GroupW-1:0] top_grp;

	assign en3     = !v_s3 || ser_ready;
	assign s2_free = !v_s2 || en3;

	always_comb begin
		top_c = '0;
		for (int i = 0; i < NumGroups; i++) begin
			if (group_of(item_s1.mag, grp_idx_t'(i)) != '0) begin
				top_c = grp_idx_t'(i);
			end
		end
	end

	assign top_grp = group_of(item_s2.mag, top_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (s2_free) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && v_s1) begin
			item_s2 <= item_s1;
			top_s2  <= top_c;
		end
		if (en3 && v_s2) begin
			job_s3.item      <= item_s2;
			job_s3.top       <= top_s2;
			job_s3.hdr_empty <= item_s2.smode & top_grp[GroupW-1];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/vle_ser.sv
// ----------------------------------------------------------------------------
// vle_ser: byte serializer
// Emits the encoded bytes of a word one byte per cycle, highest group first.
// ----------------------------------------------------------------------------
`default_nettype none

module vle_ser
	import vle_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      job_valid,
	input  wire vle_job_t  job,
	output logic           ready,
	output logic           strobe,
	output logic [7:0]     out_byte,
	output logic           last_byte
);

	logic              act_q;
	logic              hdr_q;
	logic              first_q;
	grp_idx_t          idx_q;
	vle_item_t         item_q;
	logic [GroupW-1:0] grp;
	logic              more;
	logic              lastc;
	logic [7:0]        byte_c;
	logic              load;

	assign grp  = group_of(item_q.mag, idx_q);
	assign more = (idx_q != '0);

	always_comb begin
		byte_c = ZeroByte;
		lastc  = !more;
		if (hdr_q) begin
			byte_c = (item_q.neg ? ContBit : ZeroByte) | MoreBit;
			lastc  = 1'b0;
		end else if (first_q && item_q.smode) begin
			byte_c = (item_q.neg ? ContBit : ZeroByte) | (more ? MoreBit : ZeroByte)
				| {2'b00, grp[GroupW-2:0]};
		end else begin
			byte_c = (more ? ContBit : ZeroByte) | {1'b0, grp};
		end
	end

	assign ready     = !act_q || lastc;
	assign load      = job_valid && ready;
	assign strobe    = act_q;
	assign out_byte  = byte_c;
	assign last_byte = act_q & lastc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= 1'b0;
			hdr_q   <= 1'b0;
			first_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			act_q   <= 1'b1;
			hdr_q   <= job.hdr_empty;
			first_q <= job.item.smode;
			idx_q   <= job.top;
		end else if (act_q) begin
			if (lastc) begin
				act_q <= 1'b0;
			end
			if (hdr_q) begin
				hdr_q   <= 1'b0;
				first_q <= 1'b0;
			end else begin
				first_q <= 1'b0;
				idx_q   <= idx_q - grp_idx_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= job.item;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/varint_encoder_signed_unsigned.sv
// ----------------------------------------------------------------------------
// varint_encoder_signed_unsigned: 64-bit variable-length quantity encoder
// A word is a 64-bit value and a mode bit. Raise start with value and
// signed_mode; the word is taken at a rising edge where busy is low. busy
// depends only on internal registers, never on start.
// Each word yields 1 to 10 encoded bytes, highest group first, each shown on
// out_byte for exactly one cycle with strobe high; last_byte marks the final
// byte of a word. The receiver cannot stall the output.
// A taken word passes the three pipeline stages and then the serializer
// register before its first byte appears.
// Throughput: the serializer emits one byte per cycle, so a word occupies it
// until its last byte is out; bytes of successive words follow with no gap
// while words keep arriving. The pipeline stages hold while the serializer
// is busy, and busy rises when they are full.
// Reset (arst_n low) empties the pipeline and the serializer at once.
// ----------------------------------------------------------------------------
`default_nettype none

module varint_encoder_signed_unsigned
	import vle_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [ValueW-1:0] value,
	input  wire logic              signed_mode,
	output logic                   strobe,
	output logic [7:0]             out_byte,
	output logic                   last_byte
);

	logic      v_s1;
	vle_item_t item_s1;
	logic      s2_free;
	logic      en1;
	logic      v_s3;
	vle_job_t  job_s3;
	logic      ser_ready;
	logic      take;

	assign en1  = !v_s1 || s2_free;
	assign busy = !en1;
	assign take = start && !busy;

	vle_mag u_mag (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en1),
		.take        (take),
		.value       (value),
		.signed_mode (signed_mode),
		.v_s1        (v_s1),
		.item_s1     (item_s1)
	);

	vle_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_s1      (v_s1),
		.item_s1   (item_s1),
		.ser_ready (ser_ready),
		.s2_free   (s2_free),
		.v_s3      (v_s3),
		.job_s3    (job_s3)
	);

	vle_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (v_s3),
		.job       (job_s3),
		.ready     (ser_ready),
		.strobe    (strobe),
		.out_byte  (out_byte),
		.last_byte (last_byte)
	);

`ifndef SYNTHESIS
	a_take_enters: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> v_s1)
		else $error("accepted word did not enter the first stage");

	a_word_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last_byte) |=> strobe)
		else $error("byte stream of a word was interrupted");

	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !ser_ready) |=> (v_s3 && $stable(job_s3)))
		else $error("stalled third stage lost or changed its word");

	a_busy_full: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (v_s1 && v_s3 && strobe))
		else $error("busy raised with an empty stage");
`endif

endmodule

`default_nettype wire

// File: verif/vle_encode_checker.sv
// ----------------------------------------------------------------------------
// vle_encode_checker: byte-stream checker for the variable-length encoder
// Watches the word handshake and the byte strobe, predicts the encoding of
// every accepted word and compares each strobed byte with the oldest
// predicted byte. Mismatches and unexpected bytes are counted.
// ----------------------------------------------------------------------------
`default_nettype none

module vle_encode_checker
	import vle_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              busy,
	input  wire logic [ValueW-1:0] value,
	input  wire logic              signed_mode,
	input  wire logic              strobe,
	input  wire logic [7:0]        out_byte,
	input  wire logic              last_byte,
	output int                     fail_count,
	output int                     pending,
	output int                     words_seen,
	output int                     signed_words,
	output int                     bytes_checked
);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} enc_byte_t;

	enc_byte_t expected_bytes[$];

	function automatic void append_byte(input logic [7:0] data, input logic last);
		enc_byte_t b;
		b.data = data;
		b.last = last;
		expected_bytes.push_back(b);
	endfunction

	function automatic void predict_encoding(input logic [ValueW-1:0] v, input logic smode);
		logic [ValueW-1:0] mag;
		logic [7:0]        grp;
		logic [7:0]        first;
		logic              neg;
		logic              emitted;
		int                len;
		int                mul;
		int                rem;
		if (!smode) begin
			emitted = 1'b0;
			for (int g = NumGroups - 1; g >= 0; g--) begin
				grp = {1'b0, 7'((v >> (g * GroupW)) & {57'd0, GroupMsk})};
				if (grp != ZeroByte || emitted || g == 0) begin
					if (g != 0) begin
						grp = grp | ContBit;
					end
					append_byte(grp, g == 0);
					emitted = 1'b1;
				end
			end
		end else begin
			neg = v[ValueW-1];
			mag = neg ? (64'd0 - v) : v;
			len = 0;
			for (int i = 0; i < ValueW; i++) begin
				if (mag[i]) begin
					len = i + 1;
				end
			end
			mul = len / GroupW;
			rem = len % GroupW;
			first = neg ? ContBit : ZeroByte;
			if (rem > 0) begin
				first = first | 8'((mag >> (mul * GroupW)) & ((64'd1 << rem) - 64'd1));
			end
			if (mul > 0) begin
				first = first | MoreBit;
			end
			append_byte(first, mul == 0);
			for (int g = mul - 1; g >= 0; g--) begin
				grp = {1'b0, 7'((mag >> (g * GroupW)) & {57'd0, GroupMsk})};
				if (g != 0) begin
					grp = grp | ContBit;
				end
				append_byte(grp, g == 0);
			end
		end
	endfunction

	initial begin
		fail_count = 0;
		pending = 0;
		words_seen = 0;
		signed_words = 0;
		bytes_checked = 0;
	end

	always @(posedge clk) begin
		enc_byte_t exp_b;
		if (arst_n) begin
			if (start && !busy) begin
				predict_encoding(value, signed_mode);
				words_seen++;
				if (signed_mode) begin
					signed_words++;
				end
			end
			if (strobe) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected byte %h (last_byte %b) with no word pending",
						out_byte, last_byte);
					fail_count++;
				end else begin
					exp_b = expected_bytes.pop_front();
					bytes_checked++;
					if (out_byte !== exp_b.data) begin
						$error("out_byte: expected %h, actual %h", exp_b.data, out_byte);
						fail_count++;
					end
					if (last_byte !== exp_b.last) begin
						$error("last_byte: expected %b, actual %b", exp_b.last, last_byte);
						fail_count++;
					end
				end
			end
			pending = expected_bytes.size();
		end
	end

endmodule

`default_nettype wire

// File: verif/varint_encoder_signed_unsigned_tb.sv
// ----------------------------------------------------------------------------
// varint_encoder_signed_unsigned_tb: testbench of the variable-length encoder
// Drives directed corner words, then random words of every bit length in both
// modes, with random gaps on the start side for some words. A checker beside
// the block predicts each byte; its failure and pending counts decide.
// ----------------------------------------------------------------------------
`default_nettype none

module varint_encoder_signed_unsigned_tb
	import vle_pkg::*;
();

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [ValueW-1:0] value;
	logic              signed_mode;
	logic              strobe;
	logic [7:0]        out_byte;
	logic              last_byte;

	int fail_count;
	int pending;
	int words_seen;
	int signed_words;
	int bytes_checked;

	varint_encoder_signed_unsigned dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.signed_mode (signed_mode),
		.strobe      (strobe),
		.out_byte    (out_byte),
		.last_byte   (last_byte)
	);

	vle_encode_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.value         (value),
		.signed_mode   (signed_mode),
		.strobe        (strobe),
		.out_byte      (out_byte),
		.last_byte     (last_byte),
		.fail_count    (fail_count),
		.pending       (pending),
		.words_seen    (words_seen),
		.signed_words  (signed_words),
		.bytes_checked (bytes_checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("Verification failed");
		$finish;
	end

	// Presents one word and holds it until the block takes it, then sometimes
	// idles for a random gap unless gaps are disabled.
	task automatic send_word(input logic [ValueW-1:0] v, input logic m, input bit gaps);
		start <= 1'b1;
		value <= v;
		signed_mode <= m;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		if (gaps && $urandom_range(99) < 35) begin
			start <= 1'b0;
			value <= {$urandom, $urandom};
			signed_mode <= 1'($urandom);
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Random value with a random exact bit length, sometimes negated, so that
	// every encoding length is reached; some words are raw 64-bit noise.
	function automatic logic [ValueW-1:0] random_value();
		logic [ValueW-1:0] v;
		int                len;
		v = {$urandom, $urandom};
		if ($urandom_range(3) != 0) begin
			len = $urandom_range(0, ValueW);
			if (len < ValueW) begin
				v = v & ((64'd1 << len) - 64'd1);
			end
			if (len > 0) begin
				v[len-1] = 1'b1;
			end
			if ($urandom_range(1) == 1) begin
				v = 64'd0 - v;
			end
		end
		return v;
	endfunction

	initial begin
		int wait_cycles;
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		signed_mode = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(64'd0, 1'b0, 1'b1);
		send_word(64'd0, 1'b1, 1'b1);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
		send_word(64'h8000_0000_0000_0000, 1'b1, 1'b0);
		send_word(64'h8000_0000_0000_0000, 1'b0, 1'b1);
		send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
		send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
		send_word(64'd1, 1'b0, 1'b0);
		send_word(64'd1, 1'b1, 1'b0);
		send_word(64'h7F, 1'b0, 1'b1);
		send_word(64'h80, 1'b0, 1'b0);
		send_word(64'h3FFF, 1'b0, 1'b1);
		send_word(64'h4000, 1'b0, 1'b0);
		send_word(64'h40, 1'b1, 1'b0);
		send_word(64'h3F, 1'b1, 1'b1);
		send_word(64'hFFFF_FFFF_FFFF_FFC0, 1'b1, 1'b0);
		send_word(64'h4000_0000_0000_0000, 1'b1, 1'b0);
		send_word(64'hC000_0000_0000_0000, 1'b1, 1'b1);
		send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0);
		send_word(64'h5555_5555_5555_5555, 1'b1, 1'b1);
		send_word(64'h2000, 1'b1, 1'b0);

		for (int i = 0; i < 420; i++) begin
			send_word(random_value(), 1'($urandom), !(i >= 150 && i < 260));
		end
		start <= 1'b0;

		wait_cycles = 0;
		while (pending != 0 && wait_cycles < 2000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (16) @(posedge clk);

		$display("Encoded %0d words (%0d in signed mode), %0d bytes checked.",
			words_seen, signed_words, bytes_checked);
		$display("Covered zero, extremes, empty top field and every length in both modes.");
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
